### sv/wevest_pkg.sv
package wevest_pkg;

  // Counter geometry; the modulus is a power of two
  localparam int CountModulus = 16384;
  localparam int CountBits    = 16;
  localparam int ModBits      = $clog2(CountModulus);
  localparam int StepW        = CountBits + 2;

  // Field widths
  localparam int VelW      = 17;
  localparam int PosW      = 32;
  localparam int AccW      = 18;
  localparam int ErrW      = 17;
  localparam int GainW     = 15;
  localparam int IntervalW = 8;
  localparam int LimitW    = 16;
  localparam int AccumW    = 32;

  localparam int FilterShift = 15;
  localparam int NudgeShift  = 3;

  // Configuration port
  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] RegDecimation = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] RegReverseLim = CfgIndexW'(1);
  localparam logic [CfgIndexW-1:0] RegForwardLim = CfgIndexW'(2);
  localparam logic [CfgIndexW-1:0] RegFilterGain = CfgIndexW'(3);

  localparam logic [IntervalW-1:0] DecimationReset = IntervalW'(10);
  localparam logic [LimitW-1:0]    ReverseReset    = LimitW'(4096);
  localparam logic [LimitW-1:0]    ForwardReset    = LimitW'(4096);
  localparam logic [GainW-1:0]     GainReset       = GainW'(8);

  localparam int QueueDepth = 2;

  typedef logic signed [StepW-1:0] wide_t;

  // One classified sample on its way from front to back
  typedef struct packed {
    logic [CountBits-1:0] count;
    logic                 update;
    logic                 seed;
  } word_t;

  // Bring a count difference back within half the modulus
  function automatic wide_t wrap_fix(input wide_t d);
    wide_t half;
    wide_t modw;
    wide_t r;
    half = StepW'(CountModulus / 2);
    modw = StepW'(CountModulus);
    r = d;
    if (r > half) r = r - modw;
    if (r < -half) r = r + modw;
    return r;
  endfunction

endpackage

### sv/wrapped_encoder_velocity_estimator.sv
// Velocity, position and acceleration estimator for a wrapping encoder
// counter. Each input word is one sample of the raw counter (modulus
// 16384) and yields exactly one result word. The first sample after reset
// seeds the last count and the unwrapped position. Every
// decimation_interval samples the block takes the wrap-corrected count
// step, replaces a step beyond the reverse or forward limit by the previous
// velocity, advances the 32-bit position, forms acceleration as the
// velocity change and low-pass filters it (gain / 2^15, 32-bit wrapping
// accumulator), then nudges the position one count toward the raw counter when
// the error is negative or at least 8. Samples that make no update return the
// held state with updated low and position_error zero. Timing: a front stage
// classifies samples at one word per cycle into a two-word queue while it is
// not full; an updating sample passes through the back end's sequencer (step,
// limit, advance, multiply, accumulate), and the back end takes no new sample
// until it is through, as the single gain multiplier and the state each update
// hands to the next keep it serial. Results sit in an output register, so the
// front keeps taking words while a result waits until the two-word queue
// fills. Write configuration only while the block is idle.
module wrapped_encoder_velocity_estimator (
  input  logic                                 clk,
  input  logic                                 rst,
  // Sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wevest_pkg::CountBits-1:0]     position_count,
  // Result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 updated,
  output logic signed [wevest_pkg::VelW-1:0]   velocity,
  output logic signed [wevest_pkg::PosW-1:0]   position,
  output logic signed [wevest_pkg::AccW-1:0]   acceleration,
  output logic signed [wevest_pkg::AccW-1:0]   accel_filtered,
  output logic signed [wevest_pkg::ErrW-1:0]   position_error,
  // Configuration writes
  input  logic                                 cfg_write,
  input  logic [wevest_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [wevest_pkg::CfgDataW-1:0]      cfg_data
);
  import wevest_pkg::*;

  // Configuration registers
  logic [IntervalW-1:0] decimation_interval;
  logic [LimitW-1:0]    reverse_speed_limit;
  logic [LimitW-1:0]    forward_speed_limit;
  logic [GainW-1:0]     accel_filter_gain;

  logic  queue_full;
  logic  push;
  word_t push_word;
  logic  pop;
  logic  head_valid;
  word_t head;

  // Decode writes; narrower registers keep the low bits of the word
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_interval <= DecimationReset;
      reverse_speed_limit <= ReverseReset;
      forward_speed_limit <= ForwardReset;
      accel_filter_gain   <= GainReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegDecimation: decimation_interval <= cfg_data[IntervalW-1:0];
        RegReverseLim: reverse_speed_limit <= cfg_data[LimitW-1:0];
        RegForwardLim: forward_speed_limit <= cfg_data[LimitW-1:0];
        RegFilterGain: accel_filter_gain   <= cfg_data[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Seed detection and decimation counting
  wevest_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .position_count      (position_count),
    .decimation_interval (decimation_interval),
    .queue_full          (queue_full),
    .push                (push),
    .push_word           (push_word)
  );

  // Decouple the one-per-cycle front (till full) from the multi-cycle back end
  wevest_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Estimator state, update sequencer and output register
  wevest_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .reverse_speed_limit (reverse_speed_limit),
    .forward_speed_limit (forward_speed_limit),
    .accel_filter_gain   (accel_filter_gain),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .updated             (updated),
    .velocity            (velocity),
    .position            (position),
    .acceleration        (acceleration),
    .accel_filtered      (accel_filtered),
    .position_error      (position_error)
  );

endmodule

### sv/wevest_front.sv
module wevest_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wevest_pkg::CountBits-1:0]    position_count,
  input  logic [wevest_pkg::IntervalW-1:0]    decimation_interval,
  input  logic                                queue_full,
  output logic                                push,
  output wevest_pkg::word_t                   push_word
);
  import wevest_pkg::*;

  logic                 seeded;
  logic [IntervalW-1:0] sample_counter;
  logic [IntervalW-1:0] sample_counter_next;
  logic                 accept;

  assign in_stall            = queue_full;
  assign accept              = in_valid && !queue_full;
  assign sample_counter_next = IntervalW'(sample_counter + 1'b1);

  assign push             = accept;
  assign push_word.count  = position_count;
  assign push_word.update = sample_counter_next >= decimation_interval;
  assign push_word.seed   = !seeded;

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded         <= 1'b0;
      sample_counter <= '0;
    end else if (accept) begin
      seeded         <= 1'b1;
      sample_counter <= push_word.update ? '0 : sample_counter_next;
    end
  end

endmodule

### sv/wevest_queue.sv
module wevest_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wevest_pkg::word_t push_word,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output wevest_pkg::word_t head
);
  import wevest_pkg::*;

  localparam int PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int FillW = $clog2(QueueDepth + 1);

  word_t           slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [FillW-1:0] fill;

  assign full       = fill == FillW'(QueueDepth);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   fill <= FillW'(fill + 1'b1);
        2'b01:   fill <= FillW'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### sv/wevest_back.sv
module wevest_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    head_valid,
  input  wevest_pkg::word_t                       head,
  output logic                                    pop,
  input  logic [wevest_pkg::LimitW-1:0]           reverse_speed_limit,
  input  logic [wevest_pkg::LimitW-1:0]           forward_speed_limit,
  input  logic [wevest_pkg::GainW-1:0]            accel_filter_gain,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    updated,
  output logic signed [wevest_pkg::VelW-1:0]      velocity,
  output logic signed [wevest_pkg::PosW-1:0]      position,
  output logic signed [wevest_pkg::AccW-1:0]      acceleration,
  output logic signed [wevest_pkg::AccW-1:0]      accel_filtered,
  output logic signed [wevest_pkg::ErrW-1:0]      position_error
);
  import wevest_pkg::*;

  typedef enum logic [2:0] {Idle, Limit, Advance, Multiply, Finish} state_t;

  localparam wide_t VelMax   = StepW'((2 ** (VelW - 1)) - 1);
  localparam wide_t VelMin   = -StepW'(2 ** (VelW - 1));
  localparam wide_t ModWide  = StepW'(CountModulus);
  localparam wide_t NudgeThr = StepW'(2 ** NudgeShift);
  localparam int    ProdW    = AccW + GainW + 2;

  state_t state;

  // Held estimator state
  logic [CountBits-1:0]     last_count;
  logic signed [VelW-1:0]   last_velocity;
  logic [PosW-1:0]          unwrapped;
  logic signed [AccW-1:0]   last_accel;
  logic [AccumW-1:0]        accum;
  logic signed [AccW-1:0]   filter_out;

  // Working registers of the update sequence
  word_t                    cur;
  wide_t                    delta;
  logic [PosW-1:0]          pos_base;
  logic signed [VelW-1:0]   step;
  logic signed [AccW-1:0]   accel;
  logic signed [AccW:0]     diff;
  logic [PosW-1:0]          pos_sum;
  logic [AccumW-1:0]        prod;
  wide_t                    perr;

  logic                     slot_free;
  logic                     out_load;
  logic [CountBits-1:0]     lc_base;
  wide_t                    raw;
  wide_t                    lv_wide;
  wide_t                    d1;
  wide_t                    d2;
  wide_t                    d_sat;
  logic signed [AccW-1:0]   accel_next;
  logic signed [ProdW-1:0]  full_prod;
  logic [ModBits-1:0]       pos_low;
  wide_t                    rem;
  logic [AccumW-1:0]        accum_next;
  logic signed [AccumW-1:0] accum_shift;
  logic [PosW-1:0]          pos_final;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = (state == Idle) && head_valid && (head.update || slot_free);

  // Load the output register with a held-state word or a finished update
  assign out_load = ((state == Idle) && pop && !head.update) ||
                    ((state == Finish) && slot_free);

  // Count step against the last update, seeding on the first word
  assign lc_base = head.seed ? head.count : last_count;
  assign raw     = $signed({2'b00, head.count}) - $signed({2'b00, lc_base});

  // Reject implausible steps, reverse test first, then clamp
  assign lv_wide = StepW'(last_velocity);
  assign d1 = (delta < -$signed({2'b00, reverse_speed_limit})) ? lv_wide : delta;
  assign d2 = (d1 > $signed({2'b00, forward_speed_limit})) ? lv_wide : d1;
  always_comb begin
    d_sat = d2;
    if (d2 > VelMax) d_sat = VelMax;
    if (d2 < VelMin) d_sat = VelMin;
  end

  assign accel_next = AccW'(step) - AccW'(last_velocity);
  assign full_prod  = diff * $signed({1'b0, accel_filter_gain});

  // Truncating remainder of the position by the power-of-two modulus
  assign pos_low = pos_sum[ModBits-1:0];
  assign rem = (pos_sum[PosW-1] && (pos_low != '0)) ?
               $signed(StepW'(pos_low)) - ModWide : $signed(StepW'(pos_low));

  assign accum_next  = accum + prod;
  assign accum_shift = $signed(accum_next) >>> FilterShift;

  always_comb begin
    pos_final = pos_sum;
    if (perr >= NudgeThr) begin
      pos_final = pos_sum - 1'b1;
    end else if (perr < 0) begin
      pos_final = pos_sum + 1'b1;
    end
  end

  assign velocity       = last_velocity;
  assign position       = unwrapped;
  assign acceleration   = last_accel;
  assign accel_filtered = filter_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= Idle;
      out_valid     <= 1'b0;
      last_count    <= '0;
      last_velocity <= '0;
      unwrapped     <= '0;
      last_accel    <= '0;
      accum         <= '0;
      filter_out    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        Idle: begin
          if (pop) begin
            if (head.update) begin
              cur      <= head;
              delta    <= wrap_fix(raw);
              pos_base <= head.seed ? PosW'(head.count) : unwrapped;
              state    <= Limit;
            end else begin
              updated        <= 1'b0;
              position_error <= '0;
              if (head.seed) begin
                last_count <= head.count;
                unwrapped  <= PosW'(head.count);
              end
            end
          end
        end
        Limit: begin
          step  <= d_sat[VelW-1:0];
          state <= Advance;
        end
        Advance: begin
          accel   <= accel_next;
          diff    <= (AccW + 1)'(accel_next) - (AccW + 1)'(filter_out);
          pos_sum <= pos_base + PosW'(step);
          state   <= Multiply;
        end
        Multiply: begin
          prod  <= full_prod[AccumW-1:0];
          perr  <= wrap_fix(rem - $signed({2'b00, cur.count}));
          state <= Finish;
        end
        Finish: begin
          if (slot_free) begin
            last_count     <= cur.count;
            last_velocity  <= step;
            last_accel     <= accel;
            unwrapped      <= pos_final;
            accum          <= accum_next;
            filter_out     <= accum_shift[AccW-1:0];
            updated        <= 1'b1;
            position_error <= perr[ErrW-1:0];
            state          <= Idle;
          end
        end
        default: state <= Idle;
      endcase
    end
  end

endmodule

### sv/wevest_checker.sv
module wevest_assertions (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                updated,
  input logic signed [wevest_pkg::VelW-1:0]  velocity,
  input logic signed [wevest_pkg::AccW-1:0]  acceleration,
  input logic signed [wevest_pkg::ErrW-1:0]  position_error
);
  import wevest_pkg::*;

  // Velocity of the last delivered word
  logic signed [VelW-1:0] prev_velocity;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_velocity <= '0;
    end else if (out_valid && !out_stall) begin
      prev_velocity <= velocity;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(velocity) && $stable(updated)
      && $stable(position_error))
    else $error("stalled result word changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_idle_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && !updated |-> position_error == '0)
    else $error("position error set on a word without update");

  a_velocity_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !updated |-> velocity == prev_velocity)
    else $error("velocity moved without an update");

  a_accel_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && updated |-> acceleration == AccW'(velocity) - AccW'(prev_velocity))
    else $error("acceleration does not match velocity change");

endmodule

bind wrapped_encoder_velocity_estimator wevest_assertions u_wevest_assertions (.*);
